>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property that holds during reset as well
`define ASSERT_CLK_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> rtl/bbi2c_pkg.sv
// package for the bit-banged two-wire command and word reader
// holds the phase type and the register indexes, no dependencies
package bbi2c_pkg;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'd0,
      PH_S0    = 5'd1,
      PH_S1    = 5'd2,
      PH_S2    = 5'd3,
      PH_S3    = 5'd4,
      PH_B0    = 5'd5,
      PH_B1    = 5'd6,
      PH_B2    = 5'd7,
      PH_A0    = 5'd8,
      PH_A1    = 5'd9,
      PH_AWAIT = 5'd10,
      PH_A3    = 5'd11,
      PH_R0    = 5'd12,
      PH_R1    = 5'd13,
      PH_E0    = 5'd14,
      PH_E1    = 5'd15,
      PH_P0    = 5'd16,
      PH_P1    = 5'd17,
      PH_P2    = 5'd18
   } phase_type;

   localparam logic [1:0] REG_COMMAND_BYTE = 2'd0;
   localparam logic [1:0] REG_HALF_PERIOD  = 2'd1;
   localparam logic [1:0] REG_ACK_TIMEOUT  = 2'd2;

   localparam logic [7:0]  COMMAND_RESET     = 8'h81;
   localparam logic [7:0]  HALF_PERIOD_RESET = 8'd5;
   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;

   localparam logic [4:0] CMD_BITS  = 5'd8;
   localparam logic [4:0] DATA_BITS = 5'd16;

endpackage

>>> rtl/bitbang_i2c_key_word_reader_core.sv
// top level of the bit-banged two-wire master: command byte out, 16-bit word in
// depends on bbi2c_pkg
//
// channel   dir  handshake            payload
// req       in   req_tvalid/tready    tdata: go, sda_in
// rsp       out  rsp_tvalid/tready    tdata: scl, sda_level, sda_drive, busy, done, key
// csr       in   csr_we               csr_addr, csr_wdata
//
// one word in, one word out; a word is taken every cycle while the output
// register is empty or being emptied, so the rate is one word per cycle
// the result is registered when the word is taken and shows in the next cycle
// a stalled output holds its word and blocks only the next input
// synchronous reset clears the bus sequencer and the output valid
module bitbang_i2c_key_word_reader_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [0] go, [1] sda_in, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [0] scl, [1] sda_level, [2] sda_drive,
                                   // [3] busy_res, [4] done_res, [20:5] key_state
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import bbi2c_pkg::*;

   logic [7:0]  command_ff;
   logic [7:0]  half_ff;
   logic [15:0] timeout_ff;

   phase_type   phase_ff, phase_in;
   logic [4:0]  bit_ff, bit_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] wait_ff, wait_in;
   logic [15:0] shift_ff, shift_in;
   logic [15:0] key_ff, key_in;

   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        go, sda;

   phase_type   eff_phase;
   logic [4:0]  eff_bit;
   logic [7:0]  eff_hold;
   logic [15:0] eff_wait;
   logic [15:0] eff_shift;

   logic        scl, lvl, drv, busy, done;
   logic [8:0]  hold_next;
   logic        over;
   logic [2:0]  bit_lo;
   logic [4:0]  bit_inc;
   logic [15:0] wait_inc;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign go         = req_tdata[0];
   assign sda        = req_tdata[1];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // start of a transaction on the same tick as go
   always_comb begin
      eff_phase = phase_ff;
      eff_bit   = bit_ff;
      eff_hold  = hold_ff;
      eff_wait  = wait_ff;
      eff_shift = shift_ff;
      if (phase_ff == PH_IDLE && go) begin
         eff_phase = PH_S0;
         eff_bit   = 5'd0;
         eff_hold  = 8'd0;
         eff_wait  = 16'd0;
         eff_shift = {8'd0, command_ff};
      end
   end

   assign bit_lo = eff_bit[2:0];

   // line levels
   always_comb begin
      scl  = 1'b1;
      lvl  = 1'b1;
      drv  = 1'b1;
      busy = (eff_phase != PH_IDLE);
      case (eff_phase)
         PH_IDLE, PH_S0, PH_S1: begin
            scl = 1'b1; lvl = 1'b1; drv = 1'b1;
         end
         PH_S2: begin
            scl = 1'b1; lvl = 1'b0; drv = 1'b1;
         end
         PH_S3: begin
            scl = 1'b0; lvl = 1'b0; drv = 1'b1;
         end
         PH_B0: begin
            scl = 1'b0; drv = 1'b1;
            lvl = (bit_lo == 3'd0) ? 1'b0 : eff_shift[3'd7 - (bit_lo - 3'd1)];
         end
         PH_B1: begin
            scl = 1'b0; drv = 1'b1; lvl = eff_shift[3'd7 - bit_lo];
         end
         PH_B2: begin
            scl = 1'b1; drv = 1'b1; lvl = eff_shift[3'd7 - bit_lo];
         end
         PH_A0, PH_R0, PH_E0: begin
            scl = 1'b0; lvl = 1'b0; drv = 1'b0;
         end
         PH_A1, PH_AWAIT, PH_A3, PH_R1: begin
            scl = 1'b1; lvl = 1'b0; drv = 1'b0;
         end
         PH_E1: begin
            scl = 1'b0; lvl = 1'b1; drv = 1'b1;
         end
         PH_P0, PH_P1: begin
            scl = 1'b1; lvl = 1'b0; drv = 1'b1;
         end
         default: begin
            scl = 1'b1; lvl = 1'b1; drv = 1'b1;
         end
      endcase
   end

   assign hold_next = {1'b0, eff_hold} + 9'd1;
   assign over      = (hold_next >= {1'b0, half_ff});
   assign bit_inc   = eff_bit + 5'd1;
   assign wait_inc  = eff_wait + 16'd1;

   // next state of the sequencer
   always_comb begin
      phase_in = eff_phase;
      bit_in   = eff_bit;
      hold_in  = eff_hold;
      wait_in  = eff_wait;
      shift_in = eff_shift;
      key_in   = key_ff;
      done     = 1'b0;
      case (eff_phase)
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         PH_S0, PH_S1, PH_S2, PH_S3, PH_B0, PH_B1, PH_A0, PH_R0,
         PH_E0, PH_E1, PH_P0, PH_P1: begin
            if (over) begin
               hold_in = 8'd0;
               if (eff_phase == PH_S3) bit_in = 5'd0;
               if (eff_phase == PH_A0) wait_in = 16'd0;
               phase_in = phase_type'(eff_phase + 5'd1);
            end else begin
               hold_in = hold_next[7:0];
            end
         end
         PH_B2: begin
            if (over) begin
               hold_in  = 8'd0;
               bit_in   = bit_inc;
               phase_in = (bit_inc >= CMD_BITS) ? PH_A0 : PH_B0;
            end else begin
               hold_in = hold_next[7:0];
            end
         end
         PH_A1: begin
            if (over) begin
               hold_in  = 8'd0;
               phase_in = PH_AWAIT;
            end else begin
               hold_in = hold_next[7:0];
            end
         end
         PH_AWAIT: begin
            hold_in = 8'd0;
            if (sda) begin
               phase_in = PH_A3;
            end else begin
               wait_in = wait_inc;
               if (wait_inc == timeout_ff) phase_in = PH_A3;
            end
         end
         PH_A3: begin
            if (over) begin
               hold_in  = 8'd0;
               bit_in   = 5'd0;
               phase_in = PH_R0;
            end else begin
               hold_in = hold_next[7:0];
            end
         end
         PH_R1: begin
            if (over) begin
               hold_in  = 8'd0;
               shift_in = {eff_shift[14:0], sda};
               bit_in   = bit_inc;
               phase_in = (bit_inc >= DATA_BITS) ? PH_E0 : PH_R0;
            end else begin
               hold_in = hold_next[7:0];
            end
         end
         PH_P2: begin
            if (over) begin
               hold_in  = 8'd0;
               key_in   = ~eff_shift;
               done     = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               hold_in = hold_next[7:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
            hold_in  = 8'd0;
         end
      endcase
   end

   assign rsp_data_in = {3'd0, key_in, done, busy, drv, drv & lvl, scl};

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff   <= COMMAND_RESET;
         half_ff      <= HALF_PERIOD_RESET;
         timeout_ff   <= ACK_TIMEOUT_RESET;
         phase_ff     <= PH_IDLE;
         bit_ff       <= 5'd0;
         hold_ff      <= 8'd0;
         wait_ff      <= 16'd0;
         shift_ff     <= 16'd0;
         key_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_COMMAND_BYTE: command_ff <= csr_wdata[7:0];
               REG_HALF_PERIOD:  half_ff    <= csr_wdata[7:0];
               REG_ACK_TIMEOUT:  timeout_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff     <= phase_in;
            bit_ff       <= bit_in;
            hold_ff      <= hold_in;
            wait_ff      <= wait_in;
            shift_ff     <= shift_in;
            key_ff       <= key_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> rtl/bbi2c_checker.sv
// port-level checks for the two-wire word reader, bound to its top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module bbi2c_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // output register empty straight after reset
   `ASSERT_CLK_NORST(a_reset_empty, clock, reset |=> !rsp_tvalid)

   // a stalled result blocks new input
   `ASSERT_CLK(a_stall_blocks, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready)

   // each taken word yields a result next cycle
   `ASSERT_CLK(a_word_out, clock, reset, (req_tvalid && req_tready) |=> rsp_tvalid)

   // the closing tick leaves the bus with both lines high and driven
   `ASSERT_CLK(a_done_idle_lines, clock, reset,
      (rsp_tvalid && rsp_tdata[4]) |->
      (rsp_tdata[3] && rsp_tdata[0] && rsp_tdata[1] && rsp_tdata[2]))

   // stalled result holds its word
   `ASSERT_CLK(a_stall_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))

endmodule

bind bitbang_i2c_key_word_reader_core bbi2c_checker u_bbi2c_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
